[design/bsu_pkg.sv]
`default_nettype none
package bsu_pkg;

  localparam int unsigned MAX_HEX_DIGITS = 4;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned ACC_W = 16;
  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RUN_W = 3;

  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U = 8'h75;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       line_done;
    logic       continues;
    logic       run_last;
  } out_t;

  typedef struct packed {
    logic [RUN_W-1:0]             n;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
    logic                         has_byte;
    logic                         line_done;
    logic                         continues;
  } run_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] value;
  } esc_t;

  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
  } utf8_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t       r;
    logic [7:0] d;
    r = '0;
    d = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      r.valid = 1'b1;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'd87;
      r.valid = 1'b1;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'd55;
      r.valid = 1'b1;
    end
    r.value = d[3:0];
    return r;
  endfunction

  function automatic esc_t escape_map(input logic [7:0] b);
    esc_t r;
    r.valid = 1'b1;
    unique case (b)
      8'h61:     r.value = 8'h07;
      8'h62:     r.value = 8'h08;
      8'h74:     r.value = 8'h09;
      8'h6E:     r.value = 8'h0A;
      8'h76:     r.value = 8'h0B;
      8'h66:     r.value = 8'h0C;
      8'h72:     r.value = 8'h0D;
      BACKSLASH: r.value = BACKSLASH;
      default: begin
        r.valid = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [ACC_W-1:0] cp);
    utf8_t r;
    r = '0;
    if (cp == '0 || cp[15:11] == 5'b11011) begin
      r.n = 2'd0;
    end else if (cp[15:7] == '0) begin
      r.n = 2'd1;
      r.bytes[0] = cp[7:0];
    end else if (cp[15:11] == '0) begin
      r.n = 2'd2;
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
    end else begin
      r.n = 2'd3;
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[design/bsu_decode.sv]
`default_nettype none
module bsu_decode
  import bsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic unicode_escapes,
  input  wire in_t  item,
  input  wire logic accept,
  output run_t      run
);

  mode_t             mode, mode_next;
  logic [CNT_W-1:0]  hex_count, hex_count_next;
  logic [ACC_W-1:0]  code_accum, code_accum_next;

  hex_t              hx;
  esc_t              esc;
  utf8_t             fl;
  logic [ACC_W-1:0]  acc_shift;
  logic [CNT_W-1:0]  cnt_inc;
  logic              flush_en;
  logic [ACC_W-1:0]  flush_cp;
  logic              plain_en;
  logic              pair_en;
  logic              single_en;
  logic [7:0]        single_val;
  logic [RUN_W-1:0]  n;

  always_comb begin
    hx = hex_digit(item.in_byte);
    esc = escape_map(item.in_byte);
    acc_shift = {code_accum[ACC_W-5:0], hx.value};
    cnt_inc = hex_count + CNT_W'(1);
    mode_next = mode;
    hex_count_next = hex_count;
    code_accum_next = code_accum;
    flush_en = 1'b0;
    flush_cp = code_accum;
    plain_en = 1'b0;
    pair_en = 1'b0;
    single_en = 1'b0;
    single_val = item.in_byte;

    unique case (mode)
      MODE_HEX: begin
        if (hx.valid) begin
          if (cnt_inc >= CNT_W'(MAX_HEX_DIGITS) || item.line_end) begin
            flush_en = 1'b1;
            flush_cp = acc_shift;
            mode_next = MODE_NORMAL;
            hex_count_next = '0;
            code_accum_next = '0;
          end else begin
            hex_count_next = cnt_inc;
            code_accum_next = acc_shift;
          end
        end else begin
          flush_en = 1'b1;
          mode_next = MODE_NORMAL;
          hex_count_next = '0;
          code_accum_next = '0;
          plain_en = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        mode_next = MODE_NORMAL;
        if (esc.valid) begin
          single_en = 1'b1;
          single_val = esc.value;
        end else if (item.in_byte == CHAR_U && unicode_escapes) begin
          mode_next = MODE_HEX;
          hex_count_next = '0;
          code_accum_next = '0;
        end else begin
          pair_en = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
        plain_en = 1'b1;
      end
    endcase

    if (plain_en) begin
      if (item.in_byte == BACKSLASH) begin
        mode_next = MODE_ESCAPE;
      end else begin
        single_en = 1'b1;
      end
    end

    fl = utf8_encode(flush_cp);
    run = '0;
    run.has_byte = 1'b1;
    n = '0;
    if (flush_en) begin
      run.bytes[2:0] = fl.bytes;
      n = RUN_W'(fl.n);
    end
    if (pair_en) begin
      run.bytes[0] = BACKSLASH;
      run.bytes[1] = item.in_byte;
      n = RUN_W'(2);
    end else if (single_en) begin
      run.bytes[n[1:0]] = single_val;
      n = n + RUN_W'(1);
    end

    run.continues = item.line_end && (mode_next == MODE_ESCAPE);
    run.line_done = item.line_end;
    if (item.line_end) begin
      mode_next = MODE_NORMAL;
      hex_count_next = '0;
      code_accum_next = '0;
      if (n == '0) begin
        n = RUN_W'(1);
        run.has_byte = 1'b0;
        run.bytes = '0;
      end
    end
    run.n = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL;
      hex_count <= '0;
      code_accum <= '0;
    end else if (accept) begin
      mode <= mode_next;
      hex_count <= hex_count_next;
      code_accum <= code_accum_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_state_clear: assert property (@(posedge clk) disable iff (rst)
    (mode != MODE_HEX) |-> (hex_count == '0 && code_accum == '0))
    else $error("hex state left over outside hex mode");
  a_line_end_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && item.line_end) |=> (mode == MODE_NORMAL))
    else $error("mode not reset after line end");
  a_hex_count_bound: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HEX) |-> (hex_count < CNT_W'(MAX_HEX_DIGITS)))
    else $error("hex digit count overflow");
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run.n <= RUN_W'(MAX_RESULTS))
    else $error("too many results for one item");
`endif

endmodule
`default_nettype wire

[design/backslash_escape_utf8_decoder.sv]
// Backslash escape decoder with \u to UTF-8 conversion, one line byte per item.
// Input channel in_valid/in_ready carries in_item (byte plus line end flag).
// Output channel out_valid/out_ready carries out_item; one input item yields
// zero to four output items, the last one marked run_last.
// Config channel cfg_valid/cfg_ready writes the unicode_escapes bit; it is
// always ready and must only be written while the block is idle.
// An input item that yields output shows its first output item from the output
// register in the cycle after it is accepted.
// Throughput: one input item per cycle while each item yields at most one
// output item and out_ready holds; an item yielding several outputs holds the
// output register until the last leaves, and the next input item is taken in
// that cycle. Items that yield nothing are taken every cycle when it is free.
// Reset (rst, synchronous): clears the decode state and the output register,
// sets unicode_escapes to 1.
// When the receiver stalls, the output item holds and in_ready drops once the
// pending run cannot drain in the current cycle.
`default_nettype none
module backslash_escape_utf8_decoder
  import bsu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_item,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic cfg_unicode_escapes
);

  logic                         unicode_escapes;
  run_t                         dec;
  logic                         accept;
  logic                         load;
  logic                         pop;
  logic [RUN_W-1:0]             rem;
  logic [MAX_RESULTS-1:0][7:0]  slots;
  logic                         run_has;
  logic                         run_done;
  logic                         run_cont;

  assign cfg_ready = 1'b1;
  assign out_valid = (rem != '0);
  assign pop = out_valid && out_ready;
  assign in_ready = (rem == '0) || (rem == RUN_W'(1) && out_ready);
  assign accept = in_valid && in_ready;
  assign load = accept && (dec.n != '0);

  bsu_decode u_decode (
    .clk             (clk),
    .rst             (rst),
    .unicode_escapes (unicode_escapes),
    .item            (in_item),
    .accept          (accept),
    .run             (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      unicode_escapes <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unicode_escapes <= cfg_unicode_escapes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (load) begin
      rem <= dec.n;
    end else if (pop) begin
      rem <= rem - RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slots <= dec.bytes;
      run_has <= dec.has_byte;
      run_done <= dec.line_done;
      run_cont <= dec.continues;
    end else if (pop) begin
      slots <= {8'h00, slots[MAX_RESULTS-1:1]};
    end
  end

  always_comb begin
    out_item.out_byte = slots[0];
    out_item.has_byte = run_has;
    out_item.run_last = (rem == RUN_W'(1));
    out_item.line_done = out_item.run_last && run_done;
    out_item.continues = out_item.run_last && run_cont;
  end

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= RUN_W'(MAX_RESULTS))
    else $error("output run count out of range");
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> (out_valid && (out_item.run_last == ($past(dec.n) == RUN_W'(1)))))
    else $error("loaded run not presented");
  a_empty_only_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.run_last) |-> out_item.has_byte)
    else $error("empty item inside a run");
  a_cont_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.continues) |-> out_item.line_done)
    else $error("continuation without line end");
`endif

endmodule
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench
  import bsu_pkg::*;
;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [63:0] ESC_SET = "abtnvfr\\";

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_unicode_escapes = 1'b1;

  backslash_escape_utf8_decoder uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_item             (in_item),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_item            (out_item),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_unicode_escapes (cfg_unicode_escapes)
  );

  always #6 clk = ~clk;

  // decoder state mirror
  logic        uni_esc = 1'b1;
  mode_t       dec_mode = MODE_NORMAL;
  logic [2:0]  hex_cnt = '0;
  logic [15:0] code_acc = '0;
  out_t        run_buf[$];
  out_t        decoded_q[$];

  in_t  raw_q[$];
  int   items_left = 0;
  int   errors = 0;
  int   cycle_cnt = 0;
  int   in_gap = 0;
  int   out_stall = 0;
  bit   calm = 1'b0;
  bit   in_took = 1'b0;
  out_t want;

  function automatic out_t data_item(logic [7:0] b);
    out_t r;
    r = '0;
    r.out_byte = b;
    r.has_byte = 1'b1;
    return r;
  endfunction

  function automatic void emit_code_point();
    if (code_acc != 16'h0000 && !(code_acc >= 16'hD800 && code_acc <= 16'hDFFF)) begin
      if (code_acc < 16'h0080) begin
        run_buf.push_back(data_item(code_acc[7:0]));
      end else if (code_acc < 16'h0800) begin
        run_buf.push_back(data_item({3'b110, code_acc[10:6]}));
        run_buf.push_back(data_item({2'b10, code_acc[5:0]}));
      end else begin
        run_buf.push_back(data_item({4'b1110, code_acc[15:12]}));
        run_buf.push_back(data_item({2'b10, code_acc[11:6]}));
        run_buf.push_back(data_item({2'b10, code_acc[5:0]}));
      end
    end
    code_acc = '0;
    hex_cnt = '0;
    dec_mode = MODE_NORMAL;
  endfunction

  function automatic void take_plain(logic [7:0] b);
    if (b == BACKSLASH) dec_mode = MODE_ESCAPE;
    else run_buf.push_back(data_item(b));
  endfunction

  function automatic void decode_byte(in_t it);
    logic [7:0] b;
    logic [3:0] nib;
    bit         is_hex;
    bit         cont;
    out_t       last;
    b = it.in_byte;
    is_hex = 1'b1;
    nib = '0;
    cont = 1'b0;
    run_buf.delete();
    if (b >= "0" && b <= "9") nib = 4'(b - "0");
    else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
    else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
    else is_hex = 1'b0;
    if (dec_mode == MODE_HEX) begin
      if (is_hex) begin
        code_acc = {code_acc[11:0], nib};
        hex_cnt = hex_cnt + 3'd1;
        if (hex_cnt >= MAX_HEX_DIGITS) emit_code_point();
      end else begin
        emit_code_point();
        take_plain(b);
      end
    end else if (dec_mode == MODE_ESCAPE) begin
      dec_mode = MODE_NORMAL;
      case (b)
        "a":       run_buf.push_back(data_item(8'h07));
        "b":       run_buf.push_back(data_item(8'h08));
        "t":       run_buf.push_back(data_item(8'h09));
        "n":       run_buf.push_back(data_item(8'h0A));
        "v":       run_buf.push_back(data_item(8'h0B));
        "f":       run_buf.push_back(data_item(8'h0C));
        "r":       run_buf.push_back(data_item(8'h0D));
        BACKSLASH: run_buf.push_back(data_item(BACKSLASH));
        default: begin
          if (b == CHAR_U && uni_esc) begin
            dec_mode = MODE_HEX;
            hex_cnt = '0;
            code_acc = '0;
          end else begin
            run_buf.push_back(data_item(BACKSLASH));
            run_buf.push_back(data_item(b));
          end
        end
      endcase
    end else begin
      dec_mode = MODE_NORMAL;
      take_plain(b);
    end
    if (it.line_end) begin
      if (dec_mode == MODE_HEX) emit_code_point();
      cont = (dec_mode == MODE_ESCAPE);
      dec_mode = MODE_NORMAL;
      hex_cnt = '0;
      code_acc = '0;
      if (run_buf.size() == 0) run_buf.push_back('0);
      last = run_buf.pop_back();
      last.line_done = 1'b1;
      last.continues = cont;
      run_buf.push_back(last);
    end
    if (run_buf.size() > 0) begin
      last = run_buf.pop_back();
      last.run_last = 1'b1;
      run_buf.push_back(last);
    end
    foreach (run_buf[i]) decoded_q.push_back(run_buf[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d, bit upper);
    if (d < 4'd10) return "0" + 8'(d);
    if (upper) return "A" - 8'd10 + 8'(d);
    return "a" - 8'd10 + 8'(d);
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap--;
        end else if (raw_q.size() > 0) begin
          in_item <= raw_q.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) out_stall = pick_gap();
      end
      if ($urandom_range(0, 79) == 0) calm = !calm;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        decode_byte(in_item);
        items_left--;
      end
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected item: out_byte %h has_byte %b", out_item.out_byte,
                 out_item.has_byte);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (out_item.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_item.out_byte);
            errors++;
          end
          if (out_item.has_byte !== want.has_byte) begin
            $error("has_byte: expected %b, got %b", want.has_byte, out_item.has_byte);
            errors++;
          end
          if (out_item.line_done !== want.line_done) begin
            $error("line_done: expected %b, got %b", want.line_done, out_item.line_done);
            errors++;
          end
          if (out_item.continues !== want.continues) begin
            $error("continues: expected %b, got %b", want.continues, out_item.continues);
            errors++;
          end
          if (out_item.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_item.run_last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_byte(logic [7:0] b, bit le);
    in_t it;
    it.in_byte = b;
    it.line_end = le;
    raw_q.push_back(it);
    items_left++;
  endtask

  task automatic queue_text(string s, bit end_line);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i], end_line && i == s.len() - 1);
  endtask

  task automatic add_line();
    logic [7:0]  ln[$];
    logic [15:0] cp;
    int          nd;
    int          kind;
    bit          upper;
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        ln.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 6) begin
        ln.push_back(BACKSLASH);
        ln.push_back(ESC_SET[8 * $urandom_range(0, 7) +: 8]);
      end else if (kind < 9) begin
        case ($urandom_range(0, 5))
          0: cp = 16'($urandom_range(1, 'h7F));
          1: cp = 16'($urandom_range('h80, 'h7FF));
          2: cp = 16'($urandom_range('h800, 'hFFFF));
          3: cp = 16'($urandom_range('hD800, 'hDFFF));
          4: cp = '0;
          default: cp = 16'($urandom);
        endcase
        nd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : MAX_HEX_DIGITS;
        upper = 1'($urandom_range(0, 1));
        ln.push_back(BACKSLASH);
        ln.push_back(CHAR_U);
        for (int i = nd - 1; i >= 0; i--) ln.push_back(hex_char(4'(cp >> (4 * i)), upper));
      end else begin
        ln.push_back(BACKSLASH);
        ln.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 6) == 0) ln.push_back(BACKSLASH);
    foreach (ln[i]) queue_byte(ln[i], i == ln.size() - 1);
  endtask

  task automatic drain();
    do @(negedge clk); while (items_left != 0 || decoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_unicode(bit v);
    cfg_unicode_escapes <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    uni_esc = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(bit unicode_on, int n_items);
    write_unicode(unicode_on);
    while (raw_q.size() < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) queue_byte(8'($urandom), $urandom_range(0, 4) == 0);
      end else begin
        add_line();
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_unicode(1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_text("\\", 1'b1);
    queue_byte(BACKSLASH, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_text("\\a\\\\", 1'b0);
    queue_text("\\u41\\t", 1'b0);
    queue_text("\\uFFFF", 1'b1);
    queue_text("\\u", 1'b1);
    queue_text("\\u-", 1'b1);
    drain();
    run_phase(1'b0, 60);
    run_phase(1'b1, 185);
    run_phase(1'b0, 55);
    run_phase(1'b1, 75);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/bsu_pkg.sv
design/bsu_decode.sv
design/backslash_escape_utf8_decoder.sv
tb/testbench.sv
